// ===== hdl/wfp_pkg.sv =====
`default_nettype none

package wfp_pkg;

	// depth of the word queue between the header parser and the output stage
	localparam int QUEUE_DEPTH = 4;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] raw;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} word_t;

endpackage

`default_nettype wire

// ===== hdl/wfp_front.sv =====
`default_nettype none

module wfp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     in_byte,
	output logic                push,
	output wfp_pkg::word_t      push_word
);

	typedef enum logic [6:0] {
		PH_HDR0  = 7'b0000001,
		PH_HDR1  = 7'b0000010,
		PH_EXT16 = 7'b0000100,
		PH_EXT64 = 7'b0001000,
		PH_KEY   = 7'b0010000,
		PH_DATA  = 7'b0100000,
		PH_ERR   = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [31:0] blen_q, blen_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] key_q, key_d;
	logic [31:0] pcount_q, pcount_d;
	logic        err_q, err_d;
	logic        hdr_done;
	logic [31:0] pcount_inc;
	logic [7:0]  key_byte;

	assign pcount_inc = pcount_q + 32'd1;
	// key byte 0 sits in the top byte
	assign key_byte = key_q[{~pcount_q[1:0], 3'b000} +: 8];

	always_comb begin
		phase_d = phase_q;
		fin_d = fin_q;
		opcode_d = opcode_q;
		mask_d = mask_q;
		blen_d = blen_q;
		cnt_d = cnt_q;
		key_d = key_q;
		pcount_d = pcount_q;
		err_d = err_q;
		hdr_done = 1'b0;
		push = 1'b0;
		push_word.kind = wfp_pkg::KIND_DATA;
		push_word.raw = in_byte;
		push_word.key = key_byte;
		push_word.opcode = opcode_q;
		push_word.fin = fin_q;
		push_word.last = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_HDR0: begin
					fin_d = in_byte[7];
					opcode_d = in_byte[3:0];
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					mask_d = in_byte[7];
					key_d = '0;
					pcount_d = '0;
					cnt_d = '0;
					blen_d = '0;
					if (in_byte[6:0] == wfp_pkg::LEN_EXT16) begin
						phase_d = PH_EXT16;
					end else if (in_byte[6:0] == wfp_pkg::LEN_EXT64) begin
						phase_d = PH_EXT64;
					end else begin
						blen_d = {25'd0, in_byte[6:0]};
						hdr_done = 1'b1;
					end
				end
				PH_EXT16: begin
					blen_d = {16'd0, blen_q[7:0], in_byte};
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd1) begin
						cnt_d = '0;
						hdr_done = 1'b1;
					end
				end
				PH_EXT64: begin
					blen_d = {blen_q[23:0], in_byte};
					// upper half of the 64-bit length must be zero
					if (cnt_q == 3'd3) begin
						if (blen_d != 32'd0) begin
							err_d = 1'b1;
						end
						blen_d = '0;
					end
					if (cnt_q == 3'd7) begin
						cnt_d = '0;
						if (err_q) begin
							phase_d = PH_ERR;
							push = 1'b1;
							push_word.kind = wfp_pkg::KIND_ERROR;
						end else begin
							hdr_done = 1'b1;
						end
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], in_byte};
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						cnt_d = '0;
						if (blen_q == 32'd0) begin
							phase_d = PH_HDR0;
							push = 1'b1;
							push_word.kind = wfp_pkg::KIND_EMPTY;
						end else begin
							phase_d = PH_DATA;
							pcount_d = '0;
						end
					end
				end
				PH_DATA: begin
					push = 1'b1;
					push_word.last = (pcount_inc == blen_q);
					pcount_d = pcount_inc;
					if (pcount_inc == blen_q) begin
						phase_d = PH_HDR0;
						pcount_d = '0;
					end
				end
				PH_ERR: begin
					// drop everything until reset
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
			if (hdr_done) begin
				if (mask_d) begin
					phase_d = PH_KEY;
					cnt_d = '0;
				end else if (blen_d == 32'd0) begin
					phase_d = PH_HDR0;
					push = 1'b1;
					push_word.kind = wfp_pkg::KIND_EMPTY;
				end else begin
					phase_d = PH_DATA;
					pcount_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			fin_q <= 1'b0;
			opcode_q <= '0;
			mask_q <= 1'b0;
			blen_q <= '0;
			cnt_q <= '0;
			key_q <= '0;
			pcount_q <= '0;
			err_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			fin_q <= fin_d;
			opcode_q <= opcode_d;
			mask_q <= mask_d;
			blen_q <= blen_d;
			cnt_q <= cnt_d;
			key_q <= key_d;
			pcount_q <= pcount_d;
			err_q <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wfp_queue.sv =====
`default_nettype none

module wfp_queue #(
	parameter int DEPTH = wfp_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wfp_pkg::word_t push_word,
	output logic                full,
	input  wire logic           pop,
	output logic                nonempty,
	output wfp_pkg::word_t      pop_word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wfp_pkg::word_t store_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_word = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wfp_back.sv =====
`default_nettype none

module wfp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           word_avail,
	input  wire wfp_pkg::word_t word,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          payload_byte,
	output logic [3:0]          frame_opcode,
	output logic                final_fragment,
	output logic                last,
	output logic                empty_frame,
	output logic                length_error
);

	logic       valid_q;
	logic [7:0] data_q;
	logic [3:0] opcode_q;
	logic       fin_q;
	logic       last_q;
	logic       empty_q;
	logic       err_q;
	logic [7:0] data_d;
	logic       last_d;
	logic       empty_d;
	logic       err_d;

	// refill the output register whenever it is free or being taken
	assign pop = word_avail && (!valid_q || !out_stall);

	always_comb begin
		data_d = '0;
		last_d = 1'b0;
		empty_d = 1'b0;
		err_d = 1'b0;
		case (word.kind)
			wfp_pkg::KIND_DATA: begin
				data_d = word.raw ^ word.key;
				last_d = word.last;
			end
			wfp_pkg::KIND_EMPTY: begin
				last_d = 1'b1;
				empty_d = 1'b1;
			end
			wfp_pkg::KIND_ERROR: begin
				err_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= word_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= data_d;
			opcode_q <= word.opcode;
			fin_q <= word.fin;
			last_q <= last_d;
			empty_q <= empty_d;
			err_q <= err_d;
		end
	end

	assign out_valid = valid_q;
	assign payload_byte = data_q;
	assign frame_opcode = opcode_q;
	assign final_fragment = fin_q;
	assign last = last_q;
	assign empty_frame = empty_q;
	assign length_error = err_q;

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_parser.sv =====
`default_nettype none

// Websocket frame deframer. One stream byte is taken per cycle while in_stall is low;
// header, extended-length and masking-key bytes give no word, each payload byte gives one
// unmasked word tagged with fin and opcode, a zero-length frame gives one empty_frame
// word, and a 64-bit length above 32 bits gives one length_error word after which every
// byte is dropped until reset. A taken byte passes through the queue and then the output
// register before it shows on out_valid; while neither side stalls, the block sustains one
// byte per cycle in and one word per cycle out. The parser writes into a QUEUE_DEPTH-word
// queue that feeds the output register; in_stall rises only while that queue is full, so
// output stalls reach the input after the queue and the output register have filled.
module websocket_frame_parser #(
	parameter int QUEUE_DEPTH = wfp_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       payload_byte,
	output logic [3:0]       frame_opcode,
	output logic             final_fragment,
	output logic             last,
	output logic             empty_frame,
	output logic             length_error
);

	logic           accept;
	logic           push;
	wfp_pkg::word_t push_word;
	logic           full;
	logic           pop;
	logic           nonempty;
	wfp_pkg::word_t pop_word;

	assign in_stall = full;
	assign accept = in_valid && !full;

	wfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.push      (push),
		.push_word (push_word)
	);

	wfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.nonempty  (nonempty),
		.pop_word  (pop_word)
	);

	wfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.word_avail     (nonempty),
		.word           (pop_word),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_byte   (payload_byte),
		.frame_opcode   (frame_opcode),
		.final_fragment (final_fragment),
		.last           (last),
		.empty_frame    (empty_frame),
		.length_error   (length_error)
	);

endmodule

`default_nettype wire

// ===== hdl/wfp_checker.sv =====
`default_nettype none

module wfp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] payload_byte,
	input wire logic [3:0] frame_opcode,
	input wire logic       final_fragment,
	input wire logic       last,
	input wire logic       empty_frame,
	input wire logic       length_error
);

	// a stalled input byte holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte))
		else $error("stalled input byte changed");

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(last)
			&& $stable(empty_frame) && $stable(length_error)
			&& $stable(frame_opcode) && $stable(final_fragment))
		else $error("stalled output word changed");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> !last && !empty_frame && payload_byte == 8'd0)
		else $error("error word carries frame flags or data");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_frame |-> last && payload_byte == 8'd0)
		else $error("empty frame word not marked last or has data");

	// the error word is the final word until reset
	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && length_error |=> !out_valid)
		else $error("word delivered after length error");

endmodule

bind websocket_frame_parser wfp_checker u_wfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.in_byte        (in_byte),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.payload_byte   (payload_byte),
	.frame_opcode   (frame_opcode),
	.final_fragment (final_fragment),
	.last           (last),
	.empty_frame    (empty_frame),
	.length_error   (length_error)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 16;

	// websocket opcodes used by the directed frames
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_RSVD_F = 4'hF;

	typedef enum logic [2:0] {
		P_HDR0, P_HDR1, P_EXT16, P_EXT64, P_KEY, P_DATA, P_ERR
	} rx_phase_t;

	typedef enum logic [1:0] {
		STYLE_PLAIN, STYLE_NOISE
	} frame_style_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
		logic       empty;
		logic       fault;
	} out_word_t;

	typedef struct packed {
		logic [7:0] in_val;
		logic       fixed;
		logic       has_word;
		out_word_t  word;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       final_fragment;
	logic       last;
	logic       empty_frame;
	logic       length_error;

	websocket_frame_parser uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_byte   (payload_byte),
		.frame_opcode   (frame_opcode),
		.final_fragment (final_fragment),
		.last           (last),
		.empty_frame    (empty_frame),
		.length_error   (length_error)
	);

	// deframer prediction state
	rx_phase_t   rx_phase = P_HDR0;
	logic        cur_fin = 1'b0;
	logic [3:0]  cur_opcode = 4'h0;
	logic        cur_masked = 1'b0;
	logic [31:0] frame_len = 32'd0;
	logic [2:0]  hdr_idx = 3'd0;
	logic [31:0] key_word = 32'd0;
	logic [31:0] data_idx = 32'd0;
	logic        len_fault = 1'b0;

	out_word_t    pending_words[$];
	stim_row_t    table_rows[$];
	frame_style_t frame_style = STYLE_PLAIN;

	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int words_checked = 0;
	int frames_closed = 0;
	int empties_seen = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic out_word_t tag_word(logic [7:0] d, logic lst, logic emp, logic flt);
		return {d, cur_opcode, cur_fin, lst, emp, flt};
	endfunction

	function automatic void close_header(output bit has, output out_word_t w);
		has = 1'b0;
		w = '0;
		if (cur_masked) begin
			rx_phase = P_KEY;
			hdr_idx = 3'd0;
		end else if (frame_len == 32'd0) begin
			rx_phase = P_HDR0;
			has = 1'b1;
			w = tag_word(8'h00, 1'b1, 1'b1, 1'b0);
		end else begin
			rx_phase = P_DATA;
			data_idx = 32'd0;
		end
	endfunction

	function automatic void deframe_byte(logic [7:0] b, output bit has, output out_word_t w);
		int sh;
		logic lst;
		has = 1'b0;
		w = '0;
		case (rx_phase)
			P_HDR0: begin
				cur_fin = b[7];
				cur_opcode = b[3:0];
				rx_phase = P_HDR1;
			end
			P_HDR1: begin
				cur_masked = b[7];
				key_word = 32'd0;
				data_idx = 32'd0;
				hdr_idx = 3'd0;
				frame_len = 32'd0;
				if (b[6:0] == wfp_pkg::LEN_EXT16) begin
					rx_phase = P_EXT16;
				end else if (b[6:0] == wfp_pkg::LEN_EXT64) begin
					rx_phase = P_EXT64;
				end else begin
					frame_len = {25'd0, b[6:0]};
					close_header(has, w);
				end
			end
			P_EXT16: begin
				frame_len = {16'h0000, frame_len[7:0], b};
				hdr_idx = hdr_idx + 3'd1;
				if (hdr_idx == 3'd2) begin
					hdr_idx = 3'd0;
					close_header(has, w);
				end
			end
			P_EXT64: begin
				frame_len = {frame_len[23:0], b};
				// upper length word done: any nonzero byte is fatal
				if (hdr_idx == 3'd3) begin
					if (frame_len != 32'd0)
						len_fault = 1'b1;
					frame_len = 32'd0;
				end
				if (hdr_idx == 3'd7) begin
					hdr_idx = 3'd0;
					if (len_fault) begin
						rx_phase = P_ERR;
						has = 1'b1;
						w = tag_word(8'h00, 1'b0, 1'b0, 1'b1);
					end else begin
						close_header(has, w);
					end
				end else begin
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			P_KEY: begin
				key_word = {key_word[23:0], b};
				hdr_idx = hdr_idx + 3'd1;
				if (hdr_idx == 3'd4) begin
					hdr_idx = 3'd0;
					if (frame_len == 32'd0) begin
						rx_phase = P_HDR0;
						has = 1'b1;
						w = tag_word(8'h00, 1'b1, 1'b1, 1'b0);
					end else begin
						rx_phase = P_DATA;
						data_idx = 32'd0;
					end
				end
			end
			P_DATA: begin
				// key byte 0 sits in the top of the key word
				sh = 24 - 8 * int'(data_idx[1:0]);
				lst = (data_idx + 32'd1 == frame_len);
				data_idx = data_idx + 32'd1;
				if (lst) begin
					rx_phase = P_HDR0;
					data_idx = 32'd0;
				end
				has = 1'b1;
				w = tag_word(b ^ key_word[sh +: 8], lst, 1'b0, 1'b0);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] hdr0(logic fin, logic [2:0] rsv, logic [3:0] op);
		return {fin, rsv, op};
	endfunction

	function automatic logic [7:0] hdr1(logic mask, logic [6:0] len7);
		return {mask, len7};
	endfunction

	function automatic stim_row_t fed(logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.in_val = b;
		return r;
	endfunction

	function automatic stim_row_t silent(logic [7:0] b);
		stim_row_t r;
		r = fed(b);
		r.fixed = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t gives(logic [7:0] b, out_word_t w);
		stim_row_t r;
		r = silent(b);
		r.has_word = 1'b1;
		r.word = w;
		return r;
	endfunction

	// choose the next stream byte from where the deframer stands; upper 64-bit
	// length bytes stay zero so the sticky error is left for the close
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		int r;
		b = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		case (rx_phase)
			P_HDR0: begin
				frame_style = (r < 15) ? STYLE_NOISE : STYLE_PLAIN;
			end
			P_HDR1: begin
				if (frame_style == STYLE_PLAIN) begin
					if (r < 68)
						b[6:0] = 7'($urandom_range(0, 6));
					else if (r < 80)
						b[6:0] = 7'($urandom_range(7, 125));
					else if (r < 90)
						b[6:0] = wfp_pkg::LEN_EXT16;
					else
						b[6:0] = wfp_pkg::LEN_EXT64;
				end
			end
			P_EXT16: begin
				if (hdr_idx == 3'd0)
					b = (r < 90) ? 8'h00 : 8'h01;
				else if (r < 50)
					b = 8'($urandom_range(0, 15));
			end
			P_EXT64: begin
				if (hdr_idx < 3'd6)
					b = 8'h00;
				else if (hdr_idx == 3'd6)
					b = (r < 90) ? 8'h00 : 8'h01;
				else if (r < 70)
					b = 8'($urandom_range(0, 20));
			end
			default: ;
		endcase
		return b;
	endfunction

	task automatic send_row(input stim_row_t row);
		bit has;
		out_word_t w;
		while ($urandom_range(0, 99) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= row.in_val;
		do @(posedge clk); while (in_stall);
		deframe_byte(row.in_val, has, w);
		bytes_sent++;
		if (row.fixed) begin
			if (row.has_word)
				pending_words.push_back(row.word);
		end else if (has) begin
			pending_words.push_back(w);
		end
	endtask

	// stop only on a frame boundary
	task automatic run_random(input int count);
		int n;
		n = 0;
		while (n < count || rx_phase != P_HDR0) begin
			send_row(fed(pick_byte()));
			n++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : drain_side
		out_word_t got;
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {payload_byte, frame_opcode, final_fragment, last, empty_frame, length_error};
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, payload %0h opcode %0h fin %0b last %0b %s",
					$time, got.data, got.opcode, got.fin, got.last,
					$sformatf("empty %0b error %0b", got.empty, got.fault));
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				check_field("payload_byte", want.data, got.data);
				check_field("frame_opcode", 8'(want.opcode), 8'(got.opcode));
				check_field("final_fragment", 8'(want.fin), 8'(got.fin));
				check_field("last", 8'(want.last), 8'(got.last));
				check_field("empty_frame", 8'(want.empty), 8'(got.empty));
				check_field("length_error", 8'(want.fault), 8'(got.fault));
				words_checked++;
				if (want.last)
					frames_closed++;
				if (want.empty)
					empties_seen++;
			end
		end
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		src_gap_pct = 31;
		sink_stall_pct = 57;
		table_rows = '{
			// zero-length ping straight after reset
			silent(hdr0(1'b1, 3'b000, OP_PING)),
			gives(hdr1(1'b0, 7'd0), {8'h00, OP_PING, 1'b1, 1'b1, 1'b1, 1'b0}),
			// unmasked one-byte frame, all-ones payload, fin clear
			silent(hdr0(1'b0, 3'b000, OP_RSVD_F)),
			silent(hdr1(1'b0, 7'd1)),
			gives(8'hFF, {8'hFF, OP_RSVD_F, 1'b0, 1'b1, 1'b0, 1'b0}),
			// reserved bits set, masked one-byte frame
			fed(hdr0(1'b1, 3'b111, OP_CONT)),
			fed(hdr1(1'b1, 7'd1)),
			fed(8'hAA), fed(8'h55), fed(8'h00), fed(8'hFF),
			fed(8'h3C),
			// 16-bit length of zero, kept though not minimal
			fed(hdr0(1'b1, 3'b000, OP_CLOSE)),
			fed(hdr1(1'b0, wfp_pkg::LEN_EXT16)),
			fed(8'h00), fed(8'h00),
			// 64-bit length of one
			fed(hdr0(1'b0, 3'b000, OP_BINARY)),
			fed(hdr1(1'b0, wfp_pkg::LEN_EXT64)),
			fed(8'h00), fed(8'h00), fed(8'h00), fed(8'h00),
			fed(8'h00), fed(8'h00), fed(8'h00), fed(8'h01),
			fed(8'h00)
		};
		foreach (table_rows[i])
			send_row(table_rows[i]);

		run_random(650);
		// hold the sender until the output side has caught up
		wait_drained();

		src_gap_pct = 57;
		sink_stall_pct = 31;
		run_random(650);
		wait_drained();

		src_gap_pct = 0;
		sink_stall_pct = 0;
		run_random(600);

		table_rows = '{
			// one nonzero byte in the upper length word trips the sticky error
			silent(hdr0(1'b1, 3'b000, OP_TEXT)),
			silent(hdr1(1'b1, wfp_pkg::LEN_EXT64)),
			silent(8'h00), silent(8'h00), silent(8'h00), silent(8'h01),
			silent(8'h00), silent(8'h00), silent(8'h00),
			gives(8'h05, {8'h00, OP_TEXT, 1'b1, 1'b0, 1'b0, 1'b1}),
			// everything after is dropped
			silent(hdr0(1'b1, 3'b000, OP_PING)),
			silent(hdr1(1'b0, 7'd0)),
			silent(8'hFF)
		};
		foreach (table_rows[i])
			send_row(table_rows[i]);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d stream bytes, %0d words checked, %0d frames closed (%0d empty).",
			bytes_sent, words_checked, frames_closed, empties_seen);
		$display("Included masked and extended-length frames, stalls on both sides and the sticky length error.");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
